// ===== design/qrs_pkg.sv =====
// Shared types, widths and codes for the quadratic root solver.
package qrs_pkg;

    localparam int COEF_W  = 16;               // coefficient width
    localparam int FRAC_W  = 16;               // fraction bits of the roots
    localparam int ROOT_W  = 33;               // width of one root field
    localparam int PROD_W  = 2 * COEF_W;       // product width
    localparam int DISC_W  = PROD_W + 4;       // discriminant, signed
    localparam int RAD_W   = PROD_W + 2;       // |discriminant|
    localparam int SQ_W    = RAD_W / 2 + FRAC_W;  // square root bits
    localparam int SREM_W  = SQ_W + 3;         // square root remainder
    localparam int NB_W    = COEF_W + FRAC_W + 1; // -b scaled, signed
    localparam int DEN_W   = COEF_W + 1;       // |2a|
    localparam int NUM_W   = SQ_W + 1;         // numerator magnitude
    localparam int DREM_W  = DEN_W + 1;        // divider remainder
    localparam int QS_W    = NUM_W + 1;        // signed quotient
    localparam int OUT_W   = 2 + 4 * ROOT_W;
    localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8;
    localparam int IN_PAD  = ((3 * COEF_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        KIND_DISTINCT = 2'd0,
        KIND_REPEATED = 2'd1,
        KIND_COMPLEX  = 2'd2,
        KIND_NO_QUAD  = 2'd3
    } kind_t;

    // item leaving the front end
    typedef struct packed {
        logic                     valid;
        kind_t                    kind;
        logic                     den_neg;
        logic [DEN_W-1:0]         den_mag;
        logic signed [NB_W-1:0]   nb;
        logic [RAD_W-1:0]         rad;
    } front_t;

    // item inside the square root pipeline
    typedef struct packed {
        logic                     valid;
        kind_t                    kind;
        logic                     den_neg;
        logic [DEN_W-1:0]         den_mag;
        logic signed [NB_W-1:0]   nb;
        logic [RAD_W-1:0]         rad;
        logic [SQ_W-1:0]          root;
        logic [SREM_W-1:0]        rem;
    } sq_t;

    // item inside the divider pipeline (two lanes)
    typedef struct packed {
        logic                     valid;
        kind_t                    kind;
        logic [DEN_W-1:0]         den_mag;
        logic                     neg0;
        logic                     neg1;
        logic [NUM_W-1:0]         q0;
        logic [NUM_W-1:0]         q1;
        logic [DREM_W-1:0]        r0;
        logic [DREM_W-1:0]        r1;
    } dv_t;

    // saturate a signed quotient to the root field
    function automatic logic [ROOT_W-1:0] sat_root(input logic signed [QS_W:0] v);
        logic signed [QS_W:0] hi;
        logic signed [QS_W:0] lo;
        hi = (QS_W+1)'((64'd1 << (ROOT_W - 1)) - 64'd1);
        lo = -hi - (QS_W+1)'(1);
        if (v > hi) begin
            sat_root = hi[ROOT_W-1:0];
        end else if (v < lo) begin
            sat_root = lo[ROOT_W-1:0];
        end else begin
            sat_root = v[ROOT_W-1:0];
        end
    endfunction

endpackage

// ===== design/qrs_front.sv =====
// Front end: products, discriminant, scaled -b and |2a|.
module qrs_front
    import qrs_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [COEF_W-1:0] a,
    input  logic signed [COEF_W-1:0] b,
    input  logic signed [COEF_W-1:0] c,
    output front_t                   front
);

    logic                     v1_reg;
    logic signed [COEF_W-1:0] a1_reg;
    logic signed [COEF_W-1:0] b1_reg;
    logic signed [PROD_W-1:0] bb_reg;
    logic signed [PROD_W-1:0] ac_reg;
    front_t                   front_reg;
    front_t                   front_next;

    logic signed [DISC_W-1:0] disc;
    logic signed [DISC_W-1:0] disc_abs;
    logic signed [NB_W-1:0]   bx;
    logic [COEF_W-1:0]        a_abs;

    // stage 1: the two products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            a1_reg <= a;
            b1_reg <= b;
            bb_reg <= b * b;
            ac_reg <= a * c;
        end
    end

    // stage 2: discriminant and divider operands
    always_comb begin
        disc     = DISC_W'(bb_reg) - (DISC_W'(ac_reg) <<< 2);
        disc_abs = disc[DISC_W-1] ? -disc : disc;
        bx       = NB_W'(b1_reg);
        a_abs    = a1_reg[COEF_W-1] ? COEF_W'(-a1_reg) : COEF_W'(a1_reg);
        front_next.valid   = v1_reg;
        front_next.den_neg = a1_reg[COEF_W-1];
        front_next.den_mag = {a_abs, 1'b0};
        front_next.nb      = -(bx <<< FRAC_W);
        front_next.rad     = disc_abs[RAD_W-1:0];
        if (a1_reg == '0) begin
            front_next.kind = KIND_NO_QUAD;
        end else if (disc[DISC_W-1]) begin
            front_next.kind = KIND_COMPLEX;
        end else if (disc == '0) begin
            front_next.kind = KIND_REPEATED;
        end else begin
            front_next.kind = KIND_DISTINCT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg.valid <= 1'b0;
        end else if (en) begin
            front_reg.valid <= front_next.valid;
        end
        if (en) begin
            front_reg.kind    <= front_next.kind;
            front_reg.den_neg <= front_next.den_neg;
            front_reg.den_mag <= front_next.den_mag;
            front_reg.nb      <= front_next.nb;
            front_reg.rad     <= front_next.rad;
        end
    end

    assign front = front_reg;

endmodule

// ===== design/qrs_sqrt.sv =====
// Square root pipeline: one restoring digit per stage.
module qrs_sqrt
    import qrs_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  front_t front,
    output sq_t    sq
);

    sq_t head;
    sq_t stg_reg [1:SQ_W];

    // the first digit stage sees the item with zero root and remainder
    always_comb begin
        head.valid   = front.valid;
        head.kind    = front.kind;
        head.den_neg = front.den_neg;
        head.den_mag = front.den_mag;
        head.nb      = front.nb;
        head.rad     = front.rad;
        head.root    = '0;
        head.rem     = '0;
    end

    for (genvar k = 0; k < SQ_W; k++) begin : g_digit
        sq_t               cur;
        sq_t               stage_next;
        logic [SREM_W-1:0] rem_sh;
        logic [SREM_W-1:0] trial;

        if (k == 0) begin : g_first
            assign cur = head;
        end else begin : g_next
            assign cur = stg_reg[k];
        end

        // bring down two radicand bits and try the next digit
        always_comb begin
            rem_sh = {cur.rem[SREM_W-3:0], cur.rad[RAD_W-1 -: 2]};
            trial  = SREM_W'({cur.root, 2'b01});
            stage_next      = cur;
            stage_next.rad  = cur.rad << 2;
            if (rem_sh >= trial) begin
                stage_next.rem  = rem_sh - trial;
                stage_next.root = {cur.root[SQ_W-2:0], 1'b1};
            end else begin
                stage_next.rem  = rem_sh;
                stage_next.root = {cur.root[SQ_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stg_reg[k+1].valid <= 1'b0;
            end else if (en) begin
                stg_reg[k+1].valid <= stage_next.valid;
            end
            if (en) begin
                stg_reg[k+1].kind    <= stage_next.kind;
                stg_reg[k+1].den_neg <= stage_next.den_neg;
                stg_reg[k+1].den_mag <= stage_next.den_mag;
                stg_reg[k+1].nb      <= stage_next.nb;
                stg_reg[k+1].rad     <= stage_next.rad;
                stg_reg[k+1].root    <= stage_next.root;
                stg_reg[k+1].rem     <= stage_next.rem;
            end
        end
    end

    assign sq = stg_reg[SQ_W];

endmodule

// ===== design/qrs_div.sv =====
// Two-lane divider pipeline by |2a|, one quotient bit per stage, then output.
module qrs_div
    import qrs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  sq_t               sq,
    output logic              out_valid,
    output logic [OUT_W-1:0]  out_data
);

    dv_t stg_reg [NUM_W+1];
    dv_t load_next;

    logic signed [QS_W-1:0] sx;
    logic signed [QS_W-1:0] num0;
    logic signed [QS_W-1:0] num1;

    // numerators per kind, split into sign and magnitude
    always_comb begin
        sx = QS_W'({1'b0, sq.root});
        num0 = QS_W'(sq.nb);
        num1 = QS_W'(sq.nb);
        unique case (sq.kind)
            KIND_DISTINCT: begin
                num0 = QS_W'(sq.nb) + sx;
                num1 = QS_W'(sq.nb) - sx;
            end
            KIND_COMPLEX: begin
                num1 = sx;
            end
            KIND_REPEATED, KIND_NO_QUAD: begin
                num1 = QS_W'(sq.nb);
            end
        endcase
        load_next.valid   = sq.valid;
        load_next.kind    = sq.kind;
        load_next.den_mag = sq.den_mag;
        load_next.neg0    = num0[QS_W-1] ^ sq.den_neg;
        load_next.neg1    = num1[QS_W-1] ^ sq.den_neg;
        load_next.q0      = num0[QS_W-1] ? NUM_W'(-num0) : NUM_W'(num0);
        load_next.q1      = num1[QS_W-1] ? NUM_W'(-num1) : NUM_W'(num1);
        load_next.r0      = '0;
        load_next.r1      = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_reg[0].valid <= 1'b0;
        end else if (en) begin
            stg_reg[0].valid <= load_next.valid;
        end
        if (en) begin
            stg_reg[0].kind    <= load_next.kind;
            stg_reg[0].den_mag <= load_next.den_mag;
            stg_reg[0].neg0    <= load_next.neg0;
            stg_reg[0].neg1    <= load_next.neg1;
            stg_reg[0].q0      <= load_next.q0;
            stg_reg[0].q1      <= load_next.q1;
            stg_reg[0].r0      <= load_next.r0;
            stg_reg[0].r1      <= load_next.r1;
        end
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_bit
        dv_t               stage_next;
        logic [DREM_W-1:0] sh0;
        logic [DREM_W-1:0] sh1;
        logic [DREM_W-1:0] d;

        // restoring step on both lanes
        always_comb begin
            d   = DREM_W'(stg_reg[k].den_mag);
            sh0 = {stg_reg[k].r0[DREM_W-2:0], stg_reg[k].q0[NUM_W-1]};
            sh1 = {stg_reg[k].r1[DREM_W-2:0], stg_reg[k].q1[NUM_W-1]};
            stage_next = stg_reg[k];
            if (sh0 >= d) begin
                stage_next.r0 = sh0 - d;
                stage_next.q0 = {stg_reg[k].q0[NUM_W-2:0], 1'b1};
            end else begin
                stage_next.r0 = sh0;
                stage_next.q0 = {stg_reg[k].q0[NUM_W-2:0], 1'b0};
            end
            if (sh1 >= d) begin
                stage_next.r1 = sh1 - d;
                stage_next.q1 = {stg_reg[k].q1[NUM_W-2:0], 1'b1};
            end else begin
                stage_next.r1 = sh1;
                stage_next.q1 = {stg_reg[k].q1[NUM_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stg_reg[k+1].valid <= 1'b0;
            end else if (en) begin
                stg_reg[k+1].valid <= stage_next.valid;
            end
            if (en) begin
                stg_reg[k+1].kind    <= stage_next.kind;
                stg_reg[k+1].den_mag <= stage_next.den_mag;
                stg_reg[k+1].neg0    <= stage_next.neg0;
                stg_reg[k+1].neg1    <= stage_next.neg1;
                stg_reg[k+1].q0      <= stage_next.q0;
                stg_reg[k+1].q1      <= stage_next.q1;
                stg_reg[k+1].r0      <= stage_next.r0;
                stg_reg[k+1].r1      <= stage_next.r1;
            end
        end
    end

    // sign fix, per-kind selection, saturation into the output register
    dv_t                    fin;
    logic signed [QS_W:0]   qs0;
    logic signed [QS_W:0]   qs1;
    logic [ROOT_W-1:0]      r1_v;
    logic [ROOT_W-1:0]      i1_v;
    logic [ROOT_W-1:0]      r2_v;
    logic [ROOT_W-1:0]      i2_v;
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_data_reg;
    logic [OUT_W-1:0]       out_data_next;

    always_comb begin
        fin = stg_reg[NUM_W];
        qs0 = fin.neg0 ? -(QS_W+1)'(fin.q0) : (QS_W+1)'(fin.q0);
        qs1 = fin.neg1 ? -(QS_W+1)'(fin.q1) : (QS_W+1)'(fin.q1);
        r1_v = '0;
        i1_v = '0;
        r2_v = '0;
        i2_v = '0;
        unique case (fin.kind)
            KIND_DISTINCT: begin
                r1_v = sat_root(qs0);
                r2_v = sat_root(qs1);
            end
            KIND_REPEATED: begin
                r1_v = sat_root(qs0);
                r2_v = r1_v;
            end
            KIND_COMPLEX: begin
                r1_v = sat_root(qs0);
                r2_v = r1_v;
                i1_v = sat_root(qs1);
                i2_v = sat_root(-qs1);
            end
            KIND_NO_QUAD: begin
                r1_v = '0;
            end
        endcase
        out_data_next = {i2_v, r2_v, i1_v, r1_v, fin.kind};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= fin.valid;
        end
        if (en) begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/quadratic_root_solver.sv =====
// Top level of the pipelined quadratic root solver.
//
//  channel | dir | handshake         | tdata (low bit first)
//  s_axis  | in  | s_tvalid/s_tready | coef_quad, coef_lin, coef_const
//  m_axis  | out | m_tvalid/m_tready | root_kind, first_real, first_imag,
//          |     |                   | second_real, second_imag
//
// One item per cycle while the output is not stalled. The stages are two front
// stages, 33 square root digit stages, a numerator stage, 34 divider stages
// and the output register.
// Reset clears only the valid bits. The whole pipeline advances whenever the
// output register is empty or being taken, so a stall freezes every stage.
module quadratic_root_solver
    import qrs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_PAD-1:0]   s_tdata,   // coef_quad, coef_lin, coef_const
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_PAD-1:0]  m_tdata    // root_kind, first_real, first_imag,
                                           // second_real, second_imag, pad
);

    logic             en;
    logic             out_valid;
    logic [OUT_W-1:0] out_data;
    front_t           front;
    sq_t              sq;

    assign en       = !out_valid || m_tready;
    assign s_tready = en;

    qrs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .a        (s_tdata[COEF_W-1:0]),
        .b        (s_tdata[2*COEF_W-1:COEF_W]),
        .c        (s_tdata[3*COEF_W-1:2*COEF_W]),
        .front    (front)
    );

    qrs_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .front   (front),
        .sq      (sq)
    );

    qrs_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .sq        (sq),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = OUT_PAD'(out_data);

endmodule

// ===== design/qrs_checker.sv =====
// Port-level checks of the quadratic root solver, bound to the top level.
module qrs_checker
    import qrs_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [OUT_PAD-1:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // zero quadratic coefficient gives all-zero roots
    a_no_quad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == KIND_NO_QUAD |-> m_tdata[OUT_W-1:2] == '0)
        else $error("nonzero roots with zero quadratic coefficient");

    // real kinds carry zero imaginary parts
    a_real_imag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == KIND_DISTINCT || m_tdata[1:0] == KIND_REPEATED)
        |-> m_tdata[2+2*ROOT_W-1:2+ROOT_W] == '0 && m_tdata[OUT_W-1:2+3*ROOT_W] == '0)
        else $error("imaginary part on real roots");

    // input is taken whenever the output side is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/quadratic_root_solver_tb.sv =====
// Self-checking testbench for the quadratic root solver stream block.
`timescale 1ns / 100ps

module quadratic_root_solver_tb;
    import qrs_pkg::*;

    typedef struct {
        logic signed [COEF_W-1:0] qa;
        logic signed [COEF_W-1:0] lb;
        logic signed [COEF_W-1:0] kc;
    } coefs_t;

    typedef struct {
        kind_t              kind;
        logic [ROOT_W-1:0]  r1;
        logic [ROOT_W-1:0]  i1;
        logic [ROOT_W-1:0]  r2;
        logic [ROOT_W-1:0]  i2;
    } roots_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_PAD-1:0]   s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_PAD-1:0]  m_tdata;

    coefs_t pending_coefs[$];
    roots_t expected_roots[$];
    int     send_wait;
    int     take_wait;
    int     mismatches;
    int     roots_checked;
    int     kind_seen[4];
    bit     stim_done;
    bit     in_fire;

    quadratic_root_solver dut (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // floor(sqrt(v) * 2^FRAC_W)
    function automatic longint unsigned isqrt_frac(input longint unsigned v);
        logic [127:0] x;
        logic [127:0] root;
        logic [127:0] bitv;
        x = 128'(v) << (2 * FRAC_W);
        root = 0;
        bitv = 128'd1 << 126;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root[63:0];
    endfunction

    function automatic logic [ROOT_W-1:0] clamp_root(input longint v);
        longint hi;
        hi = (longint'(1) << (ROOT_W - 1)) - 1;
        if (v > hi) v = hi;
        if (v < -hi - 1) v = -hi - 1;
        return v[ROOT_W-1:0];
    endfunction

    // expected roots of one coefficient set; SV integer divide truncates to zero
    function automatic roots_t solve_roots(input coefs_t c);
        roots_t r;
        longint a, b, k, disc, den, nb, s, re1, re2, im;
        a = c.qa; b = c.lb; k = c.kc;
        re1 = 0; re2 = 0; im = 0;
        if (a == 0) begin
            r.kind = KIND_NO_QUAD;
        end else begin
            disc = b * b - 4 * a * k;
            den = 2 * a;
            nb = -b * (longint'(1) << FRAC_W);
            s = longint'(isqrt_frac(disc < 0 ? -disc : disc));
            if (disc > 0) begin
                r.kind = KIND_DISTINCT;
                re1 = (nb + s) / den;
                re2 = (nb - s) / den;
            end else begin
                r.kind = (disc == 0) ? KIND_REPEATED : KIND_COMPLEX;
                re1 = nb / den;
                re2 = re1;
                if (disc < 0) im = s / den;
            end
        end
        r.r1 = clamp_root(re1);
        r.r2 = clamp_root(re2);
        r.i1 = clamp_root(im);
        r.i2 = clamp_root(-im);
        return r;
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 9))
            0: return COEF_W'($urandom_range(0, 1) ? 32767 : -32768);
            1, 2: return COEF_W'(int'($urandom_range(0, 40)) - 20);
            3: return '0;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic coefs_t mk(input int a, input int b, input int c);
        coefs_t x;
        x.qa = COEF_W'(a); x.lb = COEF_W'(b); x.kc = COEF_W'(c);
        return x;
    endfunction

    // stimulus
    initial begin
        coefs_t c;
        int     a, r;
        pending_coefs.push_back(mk(1, -3, 2));
        pending_coefs.push_back(mk(1, 2, 1));
        pending_coefs.push_back(mk(1, 0, 1));
        pending_coefs.push_back(mk(0, 5, 7));
        pending_coefs.push_back(mk(0, 0, 0));
        pending_coefs.push_back(mk(-1, 0, 4));
        pending_coefs.push_back(mk(32767, 32767, 32767));
        pending_coefs.push_back(mk(-32768, -32768, -32768));
        pending_coefs.push_back(mk(-32768, 32767, 32767));
        pending_coefs.push_back(mk(1, -32768, 0));
        pending_coefs.push_back(mk(1, 32767, -32768));
        pending_coefs.push_back(mk(-1, -32768, 32767));
        pending_coefs.push_back(mk(1, -32768, -32768));
        pending_coefs.push_back(mk(2, 4, 2));
        pending_coefs.push_back(mk(-3, 5, -7));
        pending_coefs.push_back(mk(32767, 0, -32768));
        pending_coefs.push_back(mk(-1, 1, -32768));
        pending_coefs.push_back(mk(3, 7, 0));
        pending_coefs.push_back(mk(-32768, 0, 0));
        for (int i = 0; i < 750; i++) begin
            c.qa = rand_coef();
            c.lb = rand_coef();
            c.kc = rand_coef();
            // perfect-square roots: a(x-r)^2 makes repeated roots while a*r*r fits COEF_W bits
            if ($urandom_range(0, 7) == 0) begin
                a = $urandom_range(1, 50);
                r = int'($urandom_range(0, 60)) - 30;
                c = mk(a, -2 * a * r, a * r * r);
            end
            pending_coefs.push_back(c);
        end
        stim_done = 1'b1;
    end

    // driver: inputs move on the falling edge
    initial begin
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        send_wait = 0; take_wait = 0; mismatches = 0; roots_checked = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
    end

    // input handshake as seen at the rising edge
    always @(posedge aclk) begin
        in_fire <= s_tvalid && s_tready;
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !in_fire) begin
                // hold the item
            end else if (send_wait > 0) begin
                s_tvalid <= 1'b0;
                send_wait <= send_wait - 1;
            end else if (pending_coefs.size() > 0) begin
                coefs_t c;
                c = pending_coefs.pop_front();
                expected_roots.push_back(solve_roots(c));
                s_tdata <= {c.kc, c.lb, c.qa};
                s_tvalid <= 1'b1;
                send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
            if (take_wait > 0) begin
                m_tready <= 1'b0;
                take_wait <= take_wait - 1;
            end else begin
                m_tready <= 1'b1;
                take_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
            end
        end
    end

    // monitor: compare every accepted result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            roots_t e;
            roots_t g;
            g.kind = kind_t'(m_tdata[1:0]);
            g.r1 = m_tdata[2 +: ROOT_W];
            g.i1 = m_tdata[2 + ROOT_W +: ROOT_W];
            g.r2 = m_tdata[2 + 2 * ROOT_W +: ROOT_W];
            g.i2 = m_tdata[2 + 3 * ROOT_W +: ROOT_W];
            if (expected_roots.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %p", g);
            end else begin
                e = expected_roots.pop_front();
                roots_checked++;
                kind_seen[e.kind]++;
                if (g.kind !== e.kind || g.r1 !== e.r1 || g.i1 !== e.i1
                        || g.r2 !== e.r2 || g.i2 !== e.i2) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at item %0d: expected %p got %p",
                                 roots_checked, e, g);
                end
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done && aresetn);
        wait (pending_coefs.size() == 0 && expected_roots.size() == 0);
        repeat (100) @(posedge aclk);
        $display("checked %0d root sets: %0d distinct, %0d repeated, %0d complex, %0d no x^2",
                 roots_checked, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        if (mismatches == 0 && expected_roots.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3000000;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/qrs_pkg.sv
design/qrs_front.sv
design/qrs_sqrt.sv
design/qrs_div.sv
design/quadratic_root_solver.sv
design/qrs_checker.sv
sim/quadratic_root_solver_tb.sv
